### design/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg: shared types and constants of the min-max contrast stretch block
// Holds the scale mode codes, register indexes, item kinds and the
// configuration bundle that the top level hands to the back end.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Scale mode codes. Code 3 is unused and behaves as byte scaling.
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_FLOOR = 2'd1;
  localparam logic [1:0] MODE_Q14   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SCALE_MODE  = 1'b0;
  localparam logic CFG_FLOOR_LEVEL = 1'b1;

  // Item kinds carried in the mode field.
  localparam logic ITEM_GATHER = 1'b0;
  localparam logic ITEM_APPLY  = 1'b1;

  // Result format.
  localparam int LEVEL_BITS = 16;
  localparam int QUOT_BITS  = 15;  // quotient never exceeds 16384
  localparam int Q14_SHIFT  = 14;
  localparam int BYTE_SHIFT = 8;
  localparam int COUNT_BITS = $clog2(QUOT_BITS);

  localparam int CFG_DATA_BITS = 8;

  typedef struct packed {
    logic [1:0] scale_mode;
    logic [7:0] floor_level;
  } cfg_t;

endpackage

### design/mcs_in_if.sv
// ----------------------------------------------------------------------------
// mcs_in_if: sample channel of the min-max contrast stretch block
// Valid/ready channel carrying the item kind, the sample and the start flag.
// ----------------------------------------------------------------------------
interface mcs_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output mode, output sample, output start_req,
                  input ready);
  modport sink   (input valid, input mode, input sample, input start_req,
                  output ready);
endinterface

### design/mcs_out_if.sv
// ----------------------------------------------------------------------------
// mcs_out_if: result channel of the min-max contrast stretch block
// Valid/ready channel carrying the normalized level and the flat flag.
// ----------------------------------------------------------------------------
interface mcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] level;
  logic               flat;

  modport source (output valid, output level, output flat, input ready);
  modport sink   (input valid, input level, input flat, output ready);
endinterface

### design/minmax_contrast_stretch.sv
// ----------------------------------------------------------------------------
// minmax_contrast_stretch: two-pass min-max normalization of height samples
// Gathers the minimum and maximum of a sample stream, then rescales samples
// against that range to 0..255, 0..255 with a floor, or Q1.14 in [-1,1].
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_ch (valid/ready). A gather item (mode 0) updates the
// running minimum and maximum, or restarts both at its sample when
// start_req is set; it produces no result. An apply item (mode 1) produces
// exactly one result on out_ch: the rescaled level and a flat flag, which is
// set with level 0 when the gathered range is empty.
// Gather items are taken one per cycle while the job queue is not full.
// Each apply item becomes a division job in a two-entry queue; a serial
// divider retires one quotient bit per cycle, so an apply item passes
// through the divider in steps: it loads the job, forms the quotient bits
// and fills the output register, where its result is offered. A run of apply
// items is therefore limited by the divider, which takes a new job only once
// the last one has left for the output register.
// The configuration port takes scale_mode (index 0) and floor_level
// (index 1); the user writes it only while idle; the block never checks it.
// Synchronous reset clears the range to 0..0, both registers to 0 and the
// queue and output register. When the receiver stalls, the result waits in
// the output register, the divider holds its finished job, and the queue
// keeps accepting items until it is full.
// ----------------------------------------------------------------------------
module minmax_contrast_stretch #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mcs_in_if.sink                            in_ch,
  mcs_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mcs_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  localparam int SB = SAMPLE_BITS;
  localparam int JW = 2 * SB + 1;

  // Configuration registers.
  logic [1:0]    scale_mode_r, scale_mode_nxt;
  logic [7:0]    floor_level_r, floor_level_nxt;
  mcs_pkg::cfg_t cfg;

  // Job path between intake, queue and divider.
  logic          q_push, q_full, q_pop, q_empty;
  logic          f_flat;
  logic [SB-1:0] f_dist, f_range;
  logic [JW-1:0] q_wdata, q_rdata;

  always_comb begin
    scale_mode_nxt  = scale_mode_r;
    floor_level_nxt = floor_level_r;
    if (cfg_we) begin
      case (cfg_index)
        mcs_pkg::CFG_SCALE_MODE:  scale_mode_nxt  = cfg_wdata[1:0];
        mcs_pkg::CFG_FLOOR_LEVEL: floor_level_nxt = cfg_wdata[7:0];
        default: begin
          scale_mode_nxt = scale_mode_r;
        end
      endcase
    end
    cfg.scale_mode  = scale_mode_r;
    cfg.floor_level = floor_level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r  <= mcs_pkg::MODE_BYTE;
      floor_level_r <= '0;
    end else begin
      scale_mode_r  <= scale_mode_nxt;
      floor_level_r <= floor_level_nxt;
    end
  end

  // Intake: range tracking and job preparation.
  mcs_front #(
    .SAMPLE_BITS(SB)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_flat  (f_flat),
    .q_dist  (f_dist),
    .q_range (f_range)
  );

  assign q_wdata = {f_flat, f_dist, f_range};

  mcs_queue #(
    .WIDTH(JW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Divider and result register.
  mcs_back #(
    .SAMPLE_BITS(SB)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_flat  (q_rdata[JW-1]),
    .q_dist  (q_rdata[JW-2:SB]),
    .q_range (q_rdata[SB-1:0]),
    .out_ch  (out_ch)
  );

  // A flat result always carries level zero.
  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.flat) |-> (out_ch.level == 16'sd0))
    else $error("flat result with nonzero level");

  // Byte modes stay within 0..255.
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (scale_mode_r != mcs_pkg::MODE_Q14))
      |-> ((out_ch.level >= 16'sd0) && (out_ch.level <= 16'sd255)))
    else $error("byte level out of range");

  // The Q1.14 mode stays within [-1,1].
  a_q14_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (scale_mode_r == mcs_pkg::MODE_Q14))
      |-> ((out_ch.level >= -16'sd16384) && (out_ch.level <= 16'sd16384)))
    else $error("Q1.14 level out of range");

  // The intake never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

endmodule

### design/mcs_front.sv
// ----------------------------------------------------------------------------
// mcs_front: item intake and range tracking
// Keeps the running minimum and maximum, and turns each apply item into a
// division job (clamped distance, range, flat flag) for the queue.
// ----------------------------------------------------------------------------
module mcs_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  mcs_in_if.sink                 in_ch,
  input  logic                   q_full,
  output logic                   q_push,
  output logic                   q_flat,
  output logic [SAMPLE_BITS-1:0] q_dist,
  output logic [SAMPLE_BITS-1:0] q_range
);
  localparam int SB = SAMPLE_BITS;

  logic signed [SB-1:0] low_r, low_nxt;
  logic signed [SB-1:0] high_r, high_nxt;
  logic [SB:0]          span;
  logic [SB:0]          dist_s;
  logic                 accept;

  always_comb begin
    in_ch.ready = !q_full;
    accept      = in_ch.valid && in_ch.ready;

    // Both differences fit SB+1 bits, so the top bit is a true sign.
    span    = {high_r[SB-1], high_r} - {low_r[SB-1], low_r};
    dist_s  = {in_ch.sample[SB-1], in_ch.sample} - {low_r[SB-1], low_r};
    q_flat  = span[SB] || (span == '0);
    q_range = span[SB-1:0];

    if (dist_s[SB]) begin
      q_dist = '0;
    end else if (dist_s[SB-1:0] > q_range) begin
      q_dist = q_range;
    end else begin
      q_dist = dist_s[SB-1:0];
    end

    q_push = accept && (in_ch.mode == mcs_pkg::ITEM_APPLY);

    low_nxt  = low_r;
    high_nxt = high_r;
    if (accept && (in_ch.mode == mcs_pkg::ITEM_GATHER)) begin
      if (in_ch.start_req) begin
        low_nxt  = in_ch.sample;
        high_nxt = in_ch.sample;
      end else begin
        if (in_ch.sample < low_r) begin
          low_nxt = in_ch.sample;
        end
        if (in_ch.sample > high_r) begin
          high_nxt = in_ch.sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

### design/mcs_queue.sv
// ----------------------------------------------------------------------------
// mcs_queue: two-entry job queue
// Decouples the intake from the divider so that each side stalls on its own.
// ----------------------------------------------------------------------------
module mcs_queue #(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  always_comb begin
    full       = (count_r == 2'(DEPTH));
    empty      = (count_r == 2'd0);
    rdata      = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### design/mcs_back.sv
// ----------------------------------------------------------------------------
// mcs_back: serial divider and result register
// Takes one job at a time, forms the scaled numerator, divides it by the
// range one quotient bit per cycle, applies the mode and holds the result.
// ----------------------------------------------------------------------------
module mcs_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mcs_pkg::cfg_t          cfg,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic                   q_flat,
  input  logic [SAMPLE_BITS-1:0] q_dist,
  input  logic [SAMPLE_BITS-1:0] q_range,
  mcs_out_if.source              out_ch
);
  localparam int SB = SAMPLE_BITS;
  localparam int QB = mcs_pkg::QUOT_BITS;
  localparam int NW = SB + QB;
  localparam int CB = mcs_pkg::COUNT_BITS;
  localparam int LB = mcs_pkg::LEVEL_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                state_r, state_nxt;
  logic [SB-1:0]         rem_r, rem_nxt;
  logic [QB-1:0]         nbits_r, nbits_nxt;
  logic [QB-1:0]         quot_r, quot_nxt;
  logic [CB-1:0]         count_r, count_nxt;
  logic [SB-1:0]         range_r, range_nxt;
  logic                  neg_r, neg_nxt;
  logic                  flat_r, flat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [LB-1:0]  out_level_r, out_level_nxt;
  logic                  out_flat_r, out_flat_nxt;

  logic [SB+1:0]         num;
  logic [SB-1:0]         mag;
  logic [NW-1:0]         numer;
  logic [SB:0]           trial;
  logic                  ge;
  logic [SB:0]           diff;
  logic [LB-1:0]         level_calc;
  logic                  out_free;

  always_comb begin
    // Numerator for the job at the queue head.
    num = {1'b0, q_dist, 1'b0} - {2'b00, q_range};
    mag = num[SB+1] ? SB'(-num) : num[SB-1:0];
    if (cfg.scale_mode == mcs_pkg::MODE_Q14) begin
      numer = NW'(mag) << mcs_pkg::Q14_SHIFT;
    end else begin
      numer = (NW'(q_dist) << mcs_pkg::BYTE_SHIFT) - NW'(q_dist);
    end

    // One restoring division step.
    trial = {rem_r, nbits_r[QB-1]};
    diff  = trial - {1'b0, range_r};
    ge    = !diff[SB] || trial[SB];

    // Mode handling on the finished quotient.
    if (flat_r) begin
      level_calc = '0;
    end else if (cfg.scale_mode == mcs_pkg::MODE_Q14) begin
      level_calc = neg_r ? LB'(-{1'b0, quot_r}) : LB'({1'b0, quot_r});
    end else if ((cfg.scale_mode == mcs_pkg::MODE_FLOOR) &&
                 (quot_r < QB'(cfg.floor_level))) begin
      level_calc = LB'(cfg.floor_level);
    end else begin
      level_calc = LB'(quot_r);
    end

    out_free = !out_valid_r || out_ch.ready;
    q_pop    = (state_r == ST_IDLE) && !q_empty;

    state_nxt     = state_r;
    rem_nxt       = rem_r;
    nbits_nxt     = nbits_r;
    quot_nxt      = quot_r;
    count_nxt     = count_r;
    range_nxt     = range_r;
    neg_nxt       = neg_r;
    flat_nxt      = flat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_level_nxt = out_level_r;
    out_flat_nxt  = out_flat_r;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          flat_nxt  = q_flat;
          range_nxt = q_range;
          neg_nxt   = num[SB+1];
          rem_nxt   = numer[NW-1:QB];
          nbits_nxt = numer[QB-1:0];
          quot_nxt  = '0;
          count_nxt = CB'(QB - 1);
          state_nxt = q_flat ? ST_HOLD : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt   = ge ? diff[SB-1:0] : trial[SB-1:0];
        quot_nxt  = {quot_r[QB-2:0], ge};
        nbits_nxt = nbits_r << 1;
        count_nxt = count_r - CB'(1);
        if (count_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_calc;
          out_flat_nxt  = flat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= rem_nxt;
    nbits_r     <= nbits_nxt;
    quot_r      <= quot_nxt;
    count_r     <= count_nxt;
    range_r     <= range_nxt;
    neg_r       <= neg_nxt;
    flat_r      <= flat_nxt;
    out_level_r <= out_level_nxt;
    out_flat_r  <= out_flat_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.level = out_level_r;
  assign out_ch.flat  = out_flat_r;

endmodule
